>>> hdl/pca_pkg.sv
// Package for the pixel colour adjust core: pixel item types, register
// indexes, mode codes and fixed-point constants.
// No dependencies.
package pca_pkg;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } t_pix_out;

    typedef enum logic [1:0] {
        MODE_BRIGHT   = 2'd0,
        MODE_CONTRAST = 2'd1,
        MODE_HSL      = 2'd2,
        MODE_HSV      = 2'd3
    } t_mode;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HUE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VAL  = 3'd4;

    localparam logic [15:0] GAIN_RST = 16'd4096;
    localparam logic [6:0]  PCT_RST  = 7'd100;

    // Q16 coefficients
    localparam logic [15:0] K_TINT = 16'd45875;
    localparam logic [15:0] LUMA_W [3] = '{16'd19595, 16'd38470, 16'd7471};

    // 255 * 4096, contrast offset
    localparam logic signed [27:0] CON_BIAS = 28'sd1044480;

    // floor(n / 100) = (n * RECIP_100) >> RECIP_SH for n < 43690
    localparam logic [12:0] RECIP_100 = 13'd5243;
    localparam int          RECIP_SH  = 19;

    // quotient of num >> 16 at which the mode 2 result saturates
    localparam logic [15:0] HSL_SAT_Q = 16'd25600;

endpackage

>>> hdl/pixel_color_adjust_core.sv
// Pixel colour adjust core: brightness, contrast and two hue tint modes.
// Depends on pca_pkg.
//
// Usage:
//   Pixels enter on i_pix when start is high and busy is low; busy is always
//   low, so one pixel can be taken on every clock.
//   Each adjusted pixel appears on o_pix for one cycle with o_valid high,
//   after it has passed through pipeline registers r1 to r9.
//   Items leave in arrival order.
//   Throughput is one item per clock, set by the nine-stage pipeline; the
//   wide multiplies (luma weights, slider products) each own a stage.
//   Registers are written through i_cfg_we / i_cfg_idx / i_cfg_data:
//   0 mode, 1 gain (Q4.12), 2 hue_angle, 3 sat_percent, 4 value_percent.
//   Other indexes are ignored. Write registers only with no items in flight.
//   The receiver cannot stall; o_valid is a strobe and must be taken.
//   Synchronous reset clears the pipeline valid bits and loads register
//   defaults: mode 0, gain 4096, hue 0, saturation 100, value 100.
module pixel_color_adjust_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  pca_pkg::t_pix_in                i_pix,
    input  logic                            i_cfg_we,
    input  logic [pca_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pca_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic                            o_valid,
    output pca_pkg::t_pix_out               o_pix
);

    localparam int DEPTH = 9;

    pca_pkg::t_mode r_mode;
    logic [15:0]    r_gain;
    logic [8:0]     r_hue;
    logic [6:0]     r_sat;
    logic [6:0]     r_val;

    logic [DEPTH-1:0] r_vld;

    logic signed [7:0] s_comp;
    logic signed [7:0] v_comp;

    // stage 1
    logic [7:0] n1_c [3];
    logic [7:0] n1_t [3];
    logic [7:0] r1_c [3];
    logic [7:0] r1_t [3];
    // stage 2
    logic [23:0]        n2_m0 [3];
    logic signed [26:0] n2_m1 [3];
    logic [24:0]        n2_p  [3];
    logic signed [16:0] n2_a  [3];
    logic [23:0]        r2_m0 [3];
    logic signed [26:0] r2_m1 [3];
    logic [24:0]        r2_p  [3];
    logic signed [16:0] r2_a  [3];
    logic [7:0]         r2_c  [3];
    logic [7:0]         r2_t  [3];
    // stage 3
    logic [7:0]  n3_y  [3];
    logic [40:0] n3_lp [3];
    logic [27:0] n3_ad [3];
    logic [7:0]  r3_y  [3];
    logic [40:0] r3_lp [3];
    logic [27:0] r3_ad [3];
    logic        r3_an [3];
    logic [24:0] r3_p  [3];
    logic [7:0]  r3_c  [3];
    logic [7:0]  r3_t  [3];
    // stage 4
    logic [24:0]       n4_luma;
    logic signed [9:0] n4_x1 [3];
    logic [24:0]       r4_luma;
    logic signed [9:0] r4_x1 [3];
    logic [7:0]        r4_y  [3];
    logic [24:0]       r4_p  [3];
    logic [7:0]        r4_c  [3];
    // stage 5
    logic [31:0]        n5_ps [3];
    logic signed [33:0] n5_ls [3];
    logic signed [17:0] n5_b  [3];
    logic [31:0]        r5_ps [3];
    logic signed [33:0] r5_ls [3];
    logic signed [17:0] r5_b  [3];
    logic signed [9:0]  r5_x1 [3];
    logic [7:0]         r5_y  [3];
    logic [7:0]         r5_c  [3];
    // stage 6
    logic [15:0]       n6_q  [3];
    logic [27:0]       n6_bd [3];
    logic [15:0]       r6_q  [3];
    logic [27:0]       r6_bd [3];
    logic              r6_bn [3];
    logic signed [9:0] r6_x1 [3];
    logic [7:0]        r6_y  [3];
    logic [7:0]        r6_c  [3];
    // stage 7
    logic [28:0]        n7_qd [3];
    logic signed [10:0] n7_x2 [3];
    logic [28:0]        r7_qd [3];
    logic               r7_qs [3];
    logic signed [10:0] r7_x2 [3];
    logic [7:0]         r7_y  [3];
    logic [7:0]         r7_c  [3];
    // stage 8
    logic [7:0]         n8_y  [3];
    logic signed [28:0] n8_p3 [3];
    logic [7:0]         r8_y  [3];
    logic signed [28:0] r8_p3 [3];
    // stage 9
    logic [7:0] n9_y [3];
    logic [7:0] r9_y [3];

    assign busy    = 1'b0;
    assign o_valid = r_vld[DEPTH-1];
    assign o_pix   = '{red_out: r9_y[0], green_out: r9_y[1], blue_out: r9_y[2]};

    assign s_comp = 8'sd100 - $signed({1'b0, r_sat});
    assign v_comp = 8'sd100 - $signed({1'b0, r_val});

    // registers and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= pca_pkg::MODE_BRIGHT;
            r_gain <= pca_pkg::GAIN_RST;
            r_hue  <= '0;
            r_sat  <= pca_pkg::PCT_RST;
            r_val  <= pca_pkg::PCT_RST;
            r_vld  <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], start & ~busy};
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pca_pkg::CFG_MODE: r_mode <= pca_pkg::t_mode'(i_cfg_data[1:0]);
                    pca_pkg::CFG_GAIN: r_gain <= i_cfg_data;
                    pca_pkg::CFG_HUE:  r_hue  <= i_cfg_data[8:0];
                    pca_pkg::CFG_SAT:  r_sat  <= i_cfg_data[6:0];
                    pca_pkg::CFG_VAL:  r_val  <= i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    // stage 1: tint from hue
    always_comb begin
        logic [8:0] kd;
        logic [5:0] k;
        logic [9:0] k17;
        logic [9:0] k17c;
        logic [7:0] up;
        logic [7:0] down;
        n1_c[0] = i_pix.red_in;
        n1_c[1] = i_pix.green_in;
        n1_c[2] = i_pix.blue_in;
        if (r_hue < 9'd60) begin
            kd = r_hue;
        end else if (r_hue < 9'd120) begin
            kd = r_hue - 9'd60;
        end else if (r_hue < 9'd180) begin
            kd = r_hue - 9'd120;
        end else if (r_hue < 9'd240) begin
            kd = r_hue - 9'd180;
        end else if (r_hue < 9'd300) begin
            kd = r_hue - 9'd240;
        end else begin
            kd = r_hue - 9'd300;
        end
        k    = kd[5:0];
        k17  = {k, 4'b0} + 10'(k);
        k17c = k17 + 10'd3;
        up   = k17[9:2];
        down = 8'd255 - k17c[9:2];
        n1_t[0] = '0;
        n1_t[1] = '0;
        n1_t[2] = '0;
        if (r_hue < 9'd60) begin
            n1_t[0] = up;
        end else if (r_hue < 9'd120) begin
            n1_t[0] = 8'd255;
            n1_t[1] = up;
        end else if (r_hue < 9'd180) begin
            n1_t[0] = down;
            n1_t[1] = 8'd255;
        end else if (r_hue < 9'd240) begin
            n1_t[1] = 8'd255;
            n1_t[2] = up;
        end else if (r_hue < 9'd300) begin
            n1_t[1] = down;
            n1_t[2] = 8'd255;
        end else if (r_hue < 9'd360) begin
            n1_t[0] = up;
            n1_t[2] = 8'd255;
        end
    end

    // stage 2: first products
    always_comb begin
        logic signed [9:0] dc;
        logic signed [8:0] am;
        for (int i = 0; i < 3; i++) begin
            dc       = $signed({1'b0, r1_c[i], 1'b0}) - 10'sd255;
            am       = $signed({1'b0, 8'd255 - r1_t[i]});
            n2_m0[i] = 24'(r1_c[i]) * 24'(r_gain);
            n2_m1[i] = 27'(dc) * 27'($signed({1'b0, r_gain}));
            n2_p[i]  = 25'({r1_c[i], 16'b0}) + 25'(pca_pkg::K_TINT) * 25'(r1_t[i]);
            n2_a[i]  = 17'(am) * 17'(s_comp);
        end
    end

    // stage 3: brightness and contrast finish, luma products, first divide
    always_comb begin
        logic [11:0]        bs;
        logic signed [27:0] cn;
        logic [13:0]        cs;
        logic [16:0]        amag;
        for (int i = 0; i < 3; i++) begin
            bs = r2_m0[i][23:12];
            cn = 28'(r2_m1[i]) + pca_pkg::CON_BIAS;
            cs = cn[26:13];
            if (r_mode == pca_pkg::MODE_BRIGHT) begin
                n3_y[i] = (|bs[11:8]) ? 8'd255 : bs[7:0];
            end else if (cn[27]) begin
                n3_y[i] = '0;
            end else begin
                n3_y[i] = (|cs[13:8]) ? 8'd255 : cs[7:0];
            end
            n3_lp[i] = 41'(r2_p[i]) * 41'(pca_pkg::LUMA_W[i]);
            amag     = r2_a[i][16] ? 17'(-r2_a[i]) : 17'(r2_a[i]);
            n3_ad[i] = 28'(amag[14:0]) * 28'(pca_pkg::RECIP_100);
        end
    end

    // stage 4: luma sum, tint moved toward white (away from it for saturation above 100)
    always_comb begin
        logic [42:0] sum;
        logic [7:0]  q;
        sum     = 43'(r3_lp[0]) + 43'(r3_lp[1]) + 43'(r3_lp[2]);
        n4_luma = sum[40:16];
        for (int i = 0; i < 3; i++) begin
            q = r3_ad[i][pca_pkg::RECIP_SH+7:pca_pkg::RECIP_SH];
            if (r3_an[i]) begin
                n4_x1[i] = $signed({2'b0, r3_t[i]}) - $signed({2'b0, q});
            end else begin
                n4_x1[i] = $signed({2'b0, r3_t[i]}) + $signed({2'b0, q});
            end
        end
    end

    // stage 5: slider products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n5_ps[i] = 32'(r4_p[i]) * 32'(r_sat);
            n5_ls[i] = 34'($signed({1'b0, r4_luma})) * 34'(s_comp);
            n5_b[i]  = 18'(r4_x1[i]) * 18'(v_comp);
        end
    end

    // stage 6: blend sum, second divide
    always_comb begin
        logic signed [34:0] num;
        logic [17:0]        bmag;
        for (int i = 0; i < 3; i++) begin
            num      = 35'($signed({1'b0, r5_ps[i]})) + 35'(r5_ls[i]);
            n6_q[i]  = num[34] ? 16'd0 : num[31:16];
            bmag     = r5_b[i][17] ? 18'(-r5_b[i]) : 18'(r5_b[i]);
            n6_bd[i] = 28'(bmag[14:0]) * 28'(pca_pkg::RECIP_100);
        end
    end

    // stage 7: divide by 100 for blend, tint scaled by value
    always_comb begin
        logic [7:0] q;
        for (int i = 0; i < 3; i++) begin
            n7_qd[i] = 29'(r6_q[i]) * 29'(pca_pkg::RECIP_100);
            q        = r6_bd[i][pca_pkg::RECIP_SH+7:pca_pkg::RECIP_SH];
            if (r6_bn[i]) begin
                n7_x2[i] = 11'(r6_x1[i]) + $signed({3'b0, q});
            end else begin
                n7_x2[i] = 11'(r6_x1[i]) - $signed({3'b0, q});
            end
        end
    end

    // stage 8: blend result, tint added
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_mode == pca_pkg::MODE_HSL) begin
                n8_y[i] = r7_qs[i] ? 8'd255
                        : r7_qd[i][pca_pkg::RECIP_SH+7:pca_pkg::RECIP_SH];
            end else begin
                n8_y[i] = r7_y[i];
            end
            n8_p3[i] = 29'($signed({1'b0, r7_c[i], 16'b0}))
                     + 29'($signed({1'b0, pca_pkg::K_TINT})) * 29'(r7_x2[i]);
        end
    end

    // stage 9: output select
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_mode != pca_pkg::MODE_HSV) begin
                n9_y[i] = r8_y[i];
            end else if (r8_p3[i][28]) begin
                n9_y[i] = '0;
            end else begin
                n9_y[i] = (|r8_p3[i][27:24]) ? 8'd255 : r8_p3[i][23:16];
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 3; i++) begin
            r1_c[i]  <= n1_c[i];
            r1_t[i]  <= n1_t[i];

            r2_m0[i] <= n2_m0[i];
            r2_m1[i] <= n2_m1[i];
            r2_p[i]  <= n2_p[i];
            r2_a[i]  <= n2_a[i];
            r2_c[i]  <= r1_c[i];
            r2_t[i]  <= r1_t[i];

            r3_y[i]  <= n3_y[i];
            r3_lp[i] <= n3_lp[i];
            r3_ad[i] <= n3_ad[i];
            r3_an[i] <= r2_a[i][16];
            r3_p[i]  <= r2_p[i];
            r3_c[i]  <= r2_c[i];
            r3_t[i]  <= r2_t[i];

            r4_x1[i] <= n4_x1[i];
            r4_y[i]  <= r3_y[i];
            r4_p[i]  <= r3_p[i];
            r4_c[i]  <= r3_c[i];

            r5_ps[i] <= n5_ps[i];
            r5_ls[i] <= n5_ls[i];
            r5_b[i]  <= n5_b[i];
            r5_x1[i] <= r4_x1[i];
            r5_y[i]  <= r4_y[i];
            r5_c[i]  <= r4_c[i];

            r6_q[i]  <= n6_q[i];
            r6_bd[i] <= n6_bd[i];
            r6_bn[i] <= r5_b[i][17];
            r6_x1[i] <= r5_x1[i];
            r6_y[i]  <= r5_y[i];
            r6_c[i]  <= r5_c[i];

            r7_qd[i] <= n7_qd[i];
            r7_qs[i] <= (r6_q[i] >= pca_pkg::HSL_SAT_Q);
            r7_x2[i] <= n7_x2[i];
            r7_y[i]  <= r6_y[i];
            r7_c[i]  <= r6_c[i];

            r8_y[i]  <= n8_y[i];
            r8_p3[i] <= n8_p3[i];

            r9_y[i]  <= n9_y[i];
        end
        r4_luma <= n4_luma;
    end

endmodule

>>> dv/pixel_color_adjust_core_tb.sv
`timescale 1ns / 1ps
// Testbench for pixel_color_adjust_core: directed table, then random phases of
// register settings and pixels, results checked against a predictor or fixed values.
// Depends on pca_pkg and the core.
module pixel_color_adjust_core_tb;

    localparam int  LAT         = 9;
    localparam int  TAIL        = 2 * LAT + 2;
    localparam int  STALL_LIMIT = 1000;
    localparam int  N_PHASES    = 24;
    localparam longint Q16      = 65536;
    localparam longint Q16_TINT = 45875;
    localparam longint LUMA_R   = 19595;
    localparam longint LUMA_G   = 38470;
    localparam longint LUMA_B   = 7471;

    typedef struct {
        pca_pkg::t_mode mode;
        logic [15:0]    gain;
        logic [8:0]     hue;
        logic [6:0]     sat;
        logic [6:0]     val;
    } t_adj_cfg;

    typedef struct packed {
        logic [pca_pkg::CFG_IDX_W-1:0]  idx;
        logic [pca_pkg::CFG_DATA_W-1:0] data;
    } t_reg_wr;

    typedef struct packed {
        logic                           is_cfg;
        logic [pca_pkg::CFG_IDX_W-1:0]  idx;
        logic [pca_pkg::CFG_DATA_W-1:0] data;
        pca_pkg::t_pix_in               pix;
        logic                           chk;
        pca_pkg::t_pix_out              want;
    } t_dir_row;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    pca_pkg::t_pix_in               i_pix;
    logic                           i_cfg_we;
    logic [pca_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [pca_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           o_valid;
    pca_pkg::t_pix_out              o_pix;

    t_adj_cfg          adj_cfg;
    pca_pkg::t_pix_out pix_expect_q [$];
    t_reg_wr           reg_wr_q [$];
    t_dir_row          dir_tab [$];
    pca_pkg::t_pix_out got_want;
    int                n_err     = 0;
    int                stall_cnt = 0;

    pixel_color_adjust_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_pix      (i_pix),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_pix      (o_pix)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] clamp_u8(longint v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    function automatic void hue_tint(input logic [8:0] h, output int tr, output int tg,
                                     output int tb);
        int hh, k, up, dn;
        hh = int'(h);
        k  = hh % 60;
        up = (17 * k) / 4;
        dn = 255 - (17 * k + 3) / 4;
        tr = 0;
        tg = 0;
        tb = 0;
        if (hh < 60) begin
            tr = up;
        end else if (hh < 120) begin
            tr = 255; tg = up;
        end else if (hh < 180) begin
            tg = 255; tr = dn;
        end else if (hh < 240) begin
            tg = 255; tb = up;
        end else if (hh < 300) begin
            tb = 255; tg = dn;
        end else if (hh < 360) begin
            tb = 255; tr = up;
        end
    endfunction

    function automatic pca_pkg::t_pix_out predict_pixel(pca_pkg::t_pix_in px);
        longint            c [3];
        longint            p [3];
        longint            o [3];
        int                t [3];
        longint            luma, num, s;
        int                x, sp, vp;
        pca_pkg::t_pix_out r;
        c[0] = longint'(px.red_in);
        c[1] = longint'(px.green_in);
        c[2] = longint'(px.blue_in);
        hue_tint(adj_cfg.hue, t[0], t[1], t[2]);
        case (adj_cfg.mode)
            pca_pkg::MODE_BRIGHT: begin
                for (int i = 0; i < 3; i++)
                    o[i] = (c[i] * longint'(adj_cfg.gain)) / 4096;
            end
            pca_pkg::MODE_CONTRAST: begin
                for (int i = 0; i < 3; i++) begin
                    num  = (2 * c[i] - 255) * longint'(adj_cfg.gain) + 255 * 4096;
                    o[i] = (num < 0) ? 0 : num / 8192;
                end
            end
            pca_pkg::MODE_HSL: begin
                s = longint'(adj_cfg.sat);
                for (int i = 0; i < 3; i++)
                    p[i] = c[i] * Q16 + Q16_TINT * longint'(t[i]);
                luma = (p[0] * LUMA_R + p[1] * LUMA_G + p[2] * LUMA_B) / Q16;
                for (int i = 0; i < 3; i++) begin
                    num  = p[i] * s + luma * (100 - s);
                    o[i] = (num < 0) ? 0 : num / (100 * Q16);
                end
            end
            default: begin
                sp = int'(adj_cfg.sat);
                vp = int'(adj_cfg.val);
                for (int i = 0; i < 3; i++) begin
                    x    = t[i];
                    x   += ((255 - x) * (100 - sp)) / 100;
                    x   -= (x * (100 - vp)) / 100;
                    p[i] = c[i] * Q16 + Q16_TINT * longint'(x);
                    o[i] = (p[i] < 0) ? 0 : p[i] / Q16;
                end
            end
        endcase
        r.red_out   = clamp_u8(o[0]);
        r.green_out = clamp_u8(o[1]);
        r.blue_out  = clamp_u8(o[2]);
        return r;
    endfunction

    function automatic t_dir_row cfg_row(logic [pca_pkg::CFG_IDX_W-1:0] idx,
                                         logic [15:0] data);
        t_dir_row r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic t_dir_row pix_row(logic [7:0] cr, logic [7:0] cg, logic [7:0] cb);
        t_dir_row r;
        r     = '0;
        r.pix = '{cr, cg, cb};
        return r;
    endfunction

    function automatic t_dir_row pix_row_chk(logic [7:0] cr, logic [7:0] cg, logic [7:0] cb,
                                             logic [7:0] wr, logic [7:0] wg, logic [7:0] wb);
        t_dir_row r;
        r      = pix_row(cr, cg, cb);
        r.chk  = 1'b1;
        r.want = '{wr, wg, wb};
        return r;
    endfunction

    function automatic logic [15:0] pct_data();
        logic [15:0] d;
        d = 16'($urandom);
        case ($urandom_range(0, 7))
            0:       d[6:0] = 7'd0;
            1:       d[6:0] = 7'd100;
            2:       d[6:0] = 7'($urandom_range(101, 127));
            default: d[6:0] = 7'($urandom_range(0, 100));
        endcase
        if ($urandom_range(0, 1) == 1) d[15:7] = '0;
        return d;
    endfunction

    function automatic pca_pkg::t_pix_in rand_pixel();
        pca_pkg::t_pix_in p;
        p.red_in   = 8'($urandom_range(0, 255));
        p.green_in = 8'($urandom_range(0, 255));
        p.blue_in  = 8'($urandom_range(0, 255));
        case ($urandom_range(0, 9))
            0: p = '0;
            1: p = '1;
            2: begin
                p.red_in   = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                p.green_in = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
                p.blue_in  = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pixel(pca_pkg::t_pix_in px, pca_pkg::t_pix_out want);
        start <= 1'b1;
        i_pix <= px;
        do @(posedge i_clk); while (busy !== 1'b0);
        pix_expect_q.push_back(want);
    endtask

    task automatic idle_gap();
        int r, n;
        r = $urandom_range(0, 99);
        if (r < 50)      n = 0;
        else if (r < 85) n = $urandom_range(1, 3);
        else if (r < 97) n = $urandom_range(4, 12);
        else             n = $urandom_range(20, 60);
        if (n != 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // every item gives one result, so an empty queue means nothing in flight
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (pix_expect_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic apply_reg_writes();
        t_reg_wr w;
        while (reg_wr_q.size() != 0) begin
            w = reg_wr_q.pop_front();
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= w.idx;
            i_cfg_data <= w.data;
            @(posedge i_clk);
            case (w.idx)
                pca_pkg::CFG_MODE: adj_cfg.mode = pca_pkg::t_mode'(w.data[1:0]);
                pca_pkg::CFG_GAIN: adj_cfg.gain = w.data;
                pca_pkg::CFG_HUE:  adj_cfg.hue  = w.data[8:0];
                pca_pkg::CFG_SAT:  adj_cfg.sat  = w.data[6:0];
                pca_pkg::CFG_VAL:  adj_cfg.val  = w.data[6:0];
                default:  ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (pix_expect_q.size() == 0) begin
                $error("o_pix: expected no item, got %h", o_pix);
                n_err++;
            end else begin
                got_want = pix_expect_q.pop_front();
                if (o_pix.red_out !== got_want.red_out) begin
                    $error("red_out: expected %0d, got %0d", got_want.red_out, o_pix.red_out);
                    n_err++;
                end
                if (o_pix.green_out !== got_want.green_out) begin
                    $error("green_out: expected %0d, got %0d", got_want.green_out,
                           o_pix.green_out);
                    n_err++;
                end
                if (o_pix.blue_out !== got_want.blue_out) begin
                    $error("blue_out: expected %0d, got %0d", got_want.blue_out,
                           o_pix.blue_out);
                    n_err++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_valid === 1'b1 || i_cfg_we) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

    initial begin
        int               n;
        logic             calm;
        logic [15:0]      d;
        pca_pkg::t_pix_in p;

        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_pix      <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        adj_cfg    = '{pca_pkg::MODE_BRIGHT, 16'd4096, 9'd0, 7'd100, 7'd100};

        dir_tab = '{
            pix_row_chk(8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0),
            pix_row_chk(8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255),
            pix_row_chk(8'h55,  8'hAA,  8'h0F,  8'h55,  8'hAA,  8'h0F),
            cfg_row(pca_pkg::CFG_GAIN, 16'hFFFF),
            pix_row_chk(8'd255, 8'd1,   8'd0,   8'd255, 8'd15,  8'd0),
            pix_row(8'd128, 8'd17, 8'd3),
            cfg_row(pca_pkg::CFG_GAIN, 16'd0),
            pix_row_chk(8'd255, 8'd255, 8'd255, 8'd0,   8'd0,   8'd0),
            // mode write with junk above the field
            cfg_row(pca_pkg::CFG_MODE, 16'hFFFD),
            pix_row_chk(8'd0,   8'd128, 8'd255, 8'd127, 8'd127, 8'd127),
            cfg_row(pca_pkg::CFG_GAIN, 16'hFFFF),
            pix_row_chk(8'd0,   8'd255, 8'd0,   8'd0,   8'd255, 8'd0),
            pix_row(8'd127, 8'd128, 8'd200),
            cfg_row(pca_pkg::CFG_GAIN, 16'd8192),
            pix_row(8'd64, 8'd100, 8'd191),
            cfg_row(pca_pkg::CFG_MODE, 16'(pca_pkg::MODE_HSL)),
            pix_row_chk(8'd10,  8'd20,  8'd30,  8'd10,  8'd20,  8'd30),
            // hue 359 with junk above the field, full desaturation
            cfg_row(pca_pkg::CFG_HUE, 16'hFF67),
            cfg_row(pca_pkg::CFG_SAT, 16'd0),
            pix_row(8'd200, 8'd50, 8'd0),
            pix_row(8'd255, 8'd255, 8'd255),
            // hue past the last segment gives no tint
            cfg_row(pca_pkg::CFG_HUE, 16'd360),
            cfg_row(pca_pkg::CFG_SAT, 16'd100),
            pix_row_chk(8'd1,   8'd2,   8'd3,   8'd1,   8'd2,   8'd3),
            cfg_row(pca_pkg::CFG_HUE, 16'd511),
            cfg_row(pca_pkg::CFG_SAT, 16'd127),
            pix_row(8'd30, 8'd200, 8'd90),
            cfg_row(pca_pkg::CFG_MODE, 16'(pca_pkg::MODE_HSV)),
            cfg_row(pca_pkg::CFG_HUE, 16'd120),
            cfg_row(pca_pkg::CFG_SAT, 16'd100),
            cfg_row(pca_pkg::CFG_VAL, 16'd100),
            pix_row(8'd255, 8'd0, 8'd0),
            cfg_row(pca_pkg::CFG_VAL, 16'd0),
            pix_row_chk(8'd9,   8'd8,   8'd7,   8'd9,   8'd8,   8'd7),
            cfg_row(pca_pkg::CFG_SAT, 16'd0),
            cfg_row(pca_pkg::CFG_VAL, 16'd100),
            pix_row(8'd0, 8'd0, 8'd0),
            cfg_row(pca_pkg::CFG_SAT, 16'd127),
            cfg_row(pca_pkg::CFG_VAL, 16'd127),
            cfg_row(pca_pkg::CFG_HUE, 16'd300),
            pix_row(8'd100, 8'd100, 8'd100),
            // writes to unused indexes must leave the registers alone
            cfg_row(3'd5, 16'hFFFF),
            cfg_row(3'd6, 16'h1234),
            cfg_row(3'd7, 16'h0000),
            pix_row(8'd100, 8'd100, 8'd100),
            cfg_row(pca_pkg::CFG_HUE, 16'h01FF),
            cfg_row(pca_pkg::CFG_SAT, 16'd100),
            cfg_row(pca_pkg::CFG_VAL, 16'd100),
            pix_row_chk(8'd77,  8'd0,   8'd255, 8'd77,  8'd0,   8'd255),
            cfg_row(pca_pkg::CFG_HUE, 16'd270),
            cfg_row(pca_pkg::CFG_SAT, 16'd50),
            cfg_row(pca_pkg::CFG_VAL, 16'd50),
            pix_row(8'd40, 8'd180, 8'd220),
            cfg_row(pca_pkg::CFG_MODE, 16'(pca_pkg::MODE_HSL)),
            cfg_row(pca_pkg::CFG_HUE, 16'd90),
            cfg_row(pca_pkg::CFG_SAT, 16'd60),
            pix_row(8'd12, 8'd240, 8'd66),
            cfg_row(pca_pkg::CFG_HUE, 16'd200),
            pix_row(8'd250, 8'd3, 8'd129),
            cfg_row(pca_pkg::CFG_HUE, 16'd150),
            pix_row(8'd90, 8'd90, 8'd255)
        };

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            if (dir_tab[i].is_cfg) begin
                reg_wr_q.push_back('{dir_tab[i].idx, dir_tab[i].data});
            end else begin
                if (reg_wr_q.size() != 0) begin
                    wait_drained();
                    apply_reg_writes();
                end
                send_pixel(dir_tab[i].pix,
                           dir_tab[i].chk ? dir_tab[i].want : predict_pixel(dir_tab[i].pix));
                idle_gap();
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++) begin
            d = 16'($urandom);
            d[1:0] = 2'(ph % 4);
            if ($urandom_range(0, 1) == 1) d[15:2] = '0;
            reg_wr_q.push_back('{pca_pkg::CFG_MODE, d});
            case ($urandom_range(0, 5))
                0:       d = 16'd0;
                1:       d = 16'hFFFF;
                2:       d = 16'd4096;
                3:       d = 16'($urandom_range(0, 8191));
                default: d = 16'($urandom);
            endcase
            reg_wr_q.push_back('{pca_pkg::CFG_GAIN, d});
            d = 16'($urandom);
            case ($urandom_range(0, 7))
                0:       d[8:0] = 9'd0;
                1:       d[8:0] = 9'd359;
                2:       d[8:0] = 9'($urandom_range(360, 511));
                3:       d[8:0] = 9'(60 * $urandom_range(1, 5));
                default: d[8:0] = 9'($urandom_range(0, 359));
            endcase
            if ($urandom_range(0, 1) == 1) d[15:9] = '0;
            reg_wr_q.push_back('{pca_pkg::CFG_HUE, d});
            reg_wr_q.push_back('{pca_pkg::CFG_SAT, pct_data()});
            reg_wr_q.push_back('{pca_pkg::CFG_VAL, pct_data()});
            if ($urandom_range(0, 3) == 0)
                reg_wr_q.push_back('{pca_pkg::CFG_IDX_W'($urandom_range(5, 7)),
                                     16'($urandom)});
            wait_drained();
            apply_reg_writes();

            n    = $urandom_range(50, 90);
            calm = ($urandom_range(0, 3) == 0);
            repeat (n) begin
                p = rand_pixel();
                send_pixel(p, predict_pixel(p));
                if (!calm) idle_gap();
                if ($urandom_range(0, 199) == 0) wait_drained();
            end
        end

        wait_drained();
        repeat (TAIL) @(posedge i_clk);
        if (n_err == 0 && pix_expect_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
